### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define VN2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent this cycle implies consequent on the next clock edge
`define VN2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vn2d_pkg.sv
// package for the 2d value noise block: item types, constants and lattice table
`timescale 1ns / 1ps

package vn2d_pkg;

  localparam int COORD_W = 24;
  localparam int NOISE_W = 16;
  localparam int BYTE_W  = 8;

  // integer part 255 wraps to grey level 0
  localparam logic [BYTE_W-1:0] PIX_MOD = 8'd255;

  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
  } vn2d_in_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise_value;
    logic [BYTE_W-1:0]  pixel_byte;
  } vn2d_out_t;

  // lattice hash bytes, index 0 first
  localparam logic [7:0] LATTICE_TAB [256] = '{
    8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78, 8'd24,
    8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247, 8'd40,
    8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76, 8'd36, 8'd1,
    8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128, 8'd167, 8'd204,
    8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102, 8'd193, 8'd189, 8'd190,
    8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77, 8'd180, 8'd204, 8'd8, 8'd81,
    8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254, 8'd210, 8'd210, 8'd177, 8'd32, 8'd81,
    8'd195, 8'd243, 8'd125, 8'd8, 8'd169, 8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13,
    8'd203, 8'd9, 8'd47, 8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181,
    8'd235, 8'd193, 8'd206, 8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41,
    8'd164, 8'd30, 8'd116, 8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206,
    8'd57, 8'd4, 8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
    8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65,
    8'd207, 8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55, 8'd89,
    8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252, 8'd90, 8'd17,
    8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177, 8'd73, 8'd174,
    8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135, 8'd19, 8'd103, 8'd13,
    8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247, 8'd33, 8'd39, 8'd145,
    8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99, 8'd41, 8'd237, 8'd203, 8'd111,
    8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30, 8'd154, 8'd120, 8'd67, 8'd87, 8'd167,
    8'd135, 8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129,
    8'd233, 8'd142, 8'd39, 8'd128, 8'd211, 8'd118, 8'd137, 8'd139, 8'd255,
    8'd114, 8'd20, 8'd218, 8'd113, 8'd154, 8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8,
    8'd198, 8'd250, 8'd209, 8'd92, 8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
  };

  // one lattice byte
  function automatic logic [7:0] lattice_byte(input logic [7:0] idx);
    return LATTICE_TAB[idx];
  endfunction

endpackage

### hdl/vn2d_weight.sv
// two-stage smoothstep weight: w = f*f*(3*2^F - 2f) >> 2F
`timescale 1ns / 1ps

module vn2d_weight #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en_a,
  input  logic                 en_b,
  input  logic [FRAC_BITS-1:0] frac,
  output logic [FRAC_BITS-1:0] weight
);

  localparam int F = FRAC_BITS;
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

  logic [F-1:0]    frac_r;
  logic [2*F-1:0]  fsq_r;
  logic [F-1:0]    weight_r;
  logic [F+1:0]    slope;
  logic [3*F+1:0]  prod;

  // first stage: square of the fraction
  always_ff @(posedge clk) begin
    if (en_a) begin
      frac_r <= frac;
      fsq_r  <= frac * frac;
    end
  end

  // second stage: scale by (3 - 2f) and drop 2F fraction bits
  always_comb begin
    slope = THREE_ONE - {1'b0, frac_r, 1'b0};
    prod  = (3*F+2)'(fsq_r) * (3*F+2)'(slope);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      weight_r <= prod[3*F-1:2*F];
    end
  end

  assign weight = weight_r;

endmodule

### hdl/value_noise_2d.sv
// 2d value noise with smoothstep blend, four-stage pipeline
`timescale 1ns / 1ps

// Takes one coordinate pair per clock unless out_ready stalls, and returns one
// noise item (Q8.8 value and grey byte). Stage 1 hashes the row and squares the
// fractions, stage 2 looks up the four corners and finishes the weights,
// stage 3 blends along x, stage 4 blends along y into the output register.
// Every stage holds its own valid bit, so stalls on out_ready back up only
// as far as needed and bubbles are squeezed out; in_ready stays high while
// any stage is free. The lattice table is constant logic. The seed is written
// through the cfg port, always ready, and should change only while idle.
module value_noise_2d #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vn2d_pkg::vn2d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vn2d_pkg::vn2d_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import vn2d_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int RSH = (F >= 8) ? F - 8 : 0;
  localparam int LSH = (F < 8) ? 8 - F : 0;

  logic [7:0] seed_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic [7:0] xi1_r, row0_r, row1_r;
  logic [7:0] c00_r, c10_r, c01_r, c11_r;
  logic [F-1:0] wx, wy;
  logic [F-1:0] wy3_r;
  logic [F+7:0] lo_r, hi_r;
  vn2d_out_t out_r;

  logic [7:0] xi, yi, ridx0, ridx1, xi1p;
  logic signed [8:0]     dlo, dhi;
  logic signed [F+9:0]   plo, phi, slo, shi;
  logic signed [F+8:0]   dv;
  logic signed [2*F+9:0] pv, sv;
  logic [F+7:0]          vq;
  logic [F+15:0]         vw;
  logic [NOISE_W-1:0]    q88;
  vn2d_out_t             out_nxt;

  // seed register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: row hash for both lattice rows
  always_comb begin
    xi    = in_data.coord_x[F +: 8];
    yi    = in_data.coord_y[F +: 8];
    ridx0 = yi + seed_r;
    ridx1 = ridx0 + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      xi1_r  <= xi;
      row0_r <= lattice_byte(ridx0);
      row1_r <= lattice_byte(ridx1);
    end
  end

  // weights over stages 1 and 2
  vn2d_weight #(.FRAC_BITS(F)) u_weight_x (
    .clk    (clk),
    .en_a   (en1),
    .en_b   (en2),
    .frac   (in_data.coord_x[F-1:0]),
    .weight (wx)
  );

  vn2d_weight #(.FRAC_BITS(F)) u_weight_y (
    .clk    (clk),
    .en_a   (en1),
    .en_b   (en2),
    .frac   (in_data.coord_y[F-1:0]),
    .weight (wy)
  );

  // stage 2: four corner lookups
  assign xi1p = xi1_r + 8'd1;

  always_ff @(posedge clk) begin
    if (en2) begin
      c00_r <= lattice_byte(row0_r + xi1_r);
      c10_r <= lattice_byte(row0_r + xi1p);
      c01_r <= lattice_byte(row1_r + xi1_r);
      c11_r <= lattice_byte(row1_r + xi1p);
    end
  end

  // stage 3: blend along x, exact since corners have no fraction bits
  always_comb begin
    dlo = $signed({1'b0, c10_r}) - $signed({1'b0, c00_r});
    dhi = $signed({1'b0, c11_r}) - $signed({1'b0, c01_r});
    plo = $signed({1'b0, wx}) * dlo;
    phi = $signed({1'b0, wx}) * dhi;
    slo = $signed({2'b00, c00_r, {F{1'b0}}}) + plo;
    shi = $signed({2'b00, c01_r, {F{1'b0}}}) + phi;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      lo_r  <= slo[F+7:0];
      hi_r  <= shi[F+7:0];
      wy3_r <= wy;
    end
  end

  // stage 4: blend along y with floor shift, rescale to Q8.8
  always_comb begin
    dv  = $signed({1'b0, hi_r}) - $signed({1'b0, lo_r});
    pv  = $signed({1'b0, wy3_r}) * dv;
    sv  = $signed({{(F+2){1'b0}}, lo_r}) + (pv >>> F);
    vq  = sv[F+7:0];
    vw  = (F+16)'(vq);
    q88 = NOISE_W'((vw >> RSH) << LSH);
    out_nxt.noise_value = q88;
    out_nxt.pixel_byte  = (q88[15:8] == PIX_MOD) ? '0 : q88[15:8];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

### hdl/vn2d_checker.sv
// port checker for the value noise block and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vn2d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input vn2d_pkg::vn2d_out_t out_data,
  input logic                cfg_ready
);

  import vn2d_pkg::*;

  // a stalled result item holds
  `VN2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled item changed")

  // grey byte never reaches the modulus
  `VN2D_ASSERT(a_pix_range, out_valid |-> out_data.pixel_byte != PIX_MOD, "pixel byte out of range")

  // grey byte follows the integer part of the value
  `VN2D_ASSERT(a_pix_match, out_valid && out_data.noise_value[15:8] != PIX_MOD |-> out_data.pixel_byte == out_data.noise_value[15:8], "pixel byte mismatch")

  // blended value never exceeds 255.0
  `VN2D_ASSERT(a_value_max, out_valid |-> out_data.noise_value <= 16'hFF00, "noise value above 255.0")

  // the seed port never stalls
  `VN2D_ASSERT(a_cfg_ready, cfg_ready, "cfg port not ready")

endmodule

bind value_noise_2d vn2d_checker u_vn2d_checker (.*);
